[rtl/core/grid_ray_caster_dda_unit_macros.svh]
// Assertion macros for the grid ray caster.
`ifndef GRID_RAY_CASTER_DDA_UNIT_MACROS_SVH
`define GRID_RAY_CASTER_DDA_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define GRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("grc assertion failed");
`define GRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("grc assertion failed");
`else
`define GRC_ASSERT(lbl, prop)
`define GRC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/grc_pkg.sv]
`default_nettype none
package grc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAP_SIDE   = 64;
  localparam int MAP_AW     = $clog2(MAP_SIDE);
  localparam int MAP_ADDR_W = 2 * MAP_AW;
  localparam int MAP_DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int MC_W       = MAP_AW + 2;
  localparam int POS_W      = 22;
  localparam int VEC_W      = 18;
  localparam int RS_W       = 12;
  localparam int COL_W      = 12;
  localparam int CELL_W     = 8;
  localparam int CFG_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CAM_W      = 31;
  localparam int PROD_W     = 49;
  localparam int RD_W       = 34;
  localparam int SD_W       = 47;
  localparam int DVD_W      = 40;
  localparam int DVS_W      = 32;
  localparam int DIV_CNT_W  = 6;
  localparam int NUM_W      = MC_W + 2 + FRAC_BITS;
  localparam int MAX_STEPS  = 2 * MAP_SIDE + 2;
  localparam int STEP_W     = 8;
  localparam int DIST_W     = 22;
  localparam int PIX_W      = 12;

  localparam logic [SD_W-1:0]   DIST_INF  = SD_W'(1) << 46;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [PIX_W-1:0]  PIX_MAX   = '1;
  localparam logic [CELL_W-1:0] WALL_BYTE = 8'd49;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y,
    REG_PLANE_X, REG_PLANE_Y, REG_RENDER_SIZE
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_WRITE,
    OP_DIV_CAM, OP_TAKE_CAM, OP_PROD, OP_RAY,
    OP_DIV_DX, OP_TAKE_DX, OP_DIV_DY, OP_TAKE_DY,
    OP_SIDE, OP_STEP, OP_HIT,
    OP_DIV_DIST, OP_TAKE_DIST, OP_DIV_LH, OP_TAKE_LH, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic clear_last;
    logic action;
    logic div_busy;
    logic div_done;
    logic off_map;
    logic wall;
    logic steps_done;
  } status_t;

  typedef struct packed {
    logic              action;
    logic [COL_W-1:0]  column;
    logic [MAP_AW-1:0] map_row;
    logic [MAP_AW-1:0] map_col;
    logic [CELL_W-1:0] cell_value;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic              wall_found;
    logic              hit_side;
    logic [MAP_AW-1:0] hit_col;
    logic [MAP_AW-1:0] hit_row;
    logic [DIST_W-1:0] wall_distance;
    logic [PIX_W-1:0]  line_height;
    logic [PIX_W-1:0]  draw_start;
    logic [PIX_W-1:0]  draw_end;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/grc_item_if.sv]
`default_nettype none
interface grc_item_if;
  import grc_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [COL_W-1:0]  column;
  logic [MAP_AW-1:0] map_row;
  logic [MAP_AW-1:0] map_col;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, action, column, map_row, map_col, cell_value, input ready);
  modport sink (input valid, action, column, map_row, map_col, cell_value, output ready);
endinterface
`default_nettype wire

[rtl/core/grc_result_if.sv]
`default_nettype none
interface grc_result_if;
  import grc_pkg::*;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column_out;
  logic              wall_found;
  logic              hit_side;
  logic [MAP_AW-1:0] hit_col;
  logic [MAP_AW-1:0] hit_row;
  logic [DIST_W-1:0] wall_distance;
  logic [PIX_W-1:0]  line_height;
  logic [PIX_W-1:0]  draw_start;
  logic [PIX_W-1:0]  draw_end;

  modport source (output valid, column_out, wall_found, hit_side, hit_col, hit_row,
                  wall_distance, line_height, draw_start, draw_end, input ready);
  modport sink (input valid, column_out, wall_found, hit_side, hit_col, hit_row,
                wall_distance, line_height, draw_start, draw_end, output ready);
endinterface
`default_nettype wire

[rtl/core/grc_ram.sv]
`default_nettype none
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/core/grc_div.sv]
`default_nettype none
module grc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [grc_pkg::DVD_W-1:0]  dividend,
  input  logic [grc_pkg::DVS_W-1:0]  divisor,
  output logic [grc_pkg::DVD_W-1:0]  quotient,
  output logic                       busy,
  output logic                       done
);
  import grc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DVD_W-2:0], ge};
      rem      <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end
endmodule
`default_nettype wire

[rtl/core/grc_datapath.sv]
`default_nettype none
module grc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grc_pkg::CFG_W-1:0]     cfg_data,
  input  grc_pkg::dp_op_t               op,
  input  grc_pkg::item_t                item,
  output grc_pkg::status_t              st,
  output grc_pkg::res_t                 res
);
  import grc_pkg::*;

  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [RS_W-1:0]         render_size;
  logic [RS_W-1:0]         rs_eff;

  logic [MAP_ADDR_W-1:0]   clr_cnt;
  item_t                   it;

  logic signed [CAM_W-1:0]  cam;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [RD_W-1:0]   rdx, rdy;
  logic [SD_W-1:0]          ddx, ddy, sdx, sdy;
  logic signed [MC_W-1:0]   mx, my;
  logic                     side;
  logic [STEP_W-1:0]        n;
  logic                     found;
  logic [DIST_W-1:0]        wall_dist;
  logic [PIX_W-1:0]         lh;

  logic [RD_W-1:0]  ax, ay;
  logic [16:0]      fracx, fracy;
  logic [63:0]      sprod_x, sprod_y;
  logic [SD_W:0]    sum_x, sum_y;
  logic [SD_W-1:0]  cap_x, cap_y;

  logic                    sel_neg, sel_zero;
  logic [RD_W-1:0]         sel_abs;
  logic [POS_W-1:0]        sel_pos;
  logic signed [MC_W-1:0]  cur_cell;
  logic signed [MC_W:0]    cell_adj;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic                    dist_neg;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dvd;
  logic [DVS_W-1:0]     div_dvs;
  logic [DVD_W-1:0]     div_q;
  logic                 div_busy, div_done;

  logic                  ram_we;
  logic [MAP_ADDR_W-1:0] ram_addr;
  logic                  ram_wdata;
  logic                  ram_rdata;

  logic [PIX_W-1:0] half_l, half_r, ds_v, de_sum, rs_m1, de_v;

  assign rs_eff = (render_size == '0) ? RS_W'(1) : render_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= POS_W'(131072);
      pos_y       <= POS_W'(131072);
      dir_x       <= -VEC_W'(65536);
      dir_y       <= '0;
      plane_x     <= '0;
      plane_y     <= VEC_W'(43254);
      render_size <= RS_W'(640);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X:       pos_x       <= cfg_data[POS_W-1:0];
        REG_POS_Y:       pos_y       <= cfg_data[POS_W-1:0];
        REG_DIR_X:       dir_x       <= cfg_data[VEC_W-1:0];
        REG_DIR_Y:       dir_y       <= cfg_data[VEC_W-1:0];
        REG_PLANE_X:     plane_x     <= cfg_data[VEC_W-1:0];
        REG_PLANE_Y:     plane_y     <= cfg_data[VEC_W-1:0];
        REG_RENDER_SIZE: render_size <= cfg_data[RS_W-1:0];
        default: ;
      endcase
    end
  end

  assign ax = rdx[RD_W-1] ? RD_W'(-rdx) : RD_W'(rdx);
  assign ay = rdy[RD_W-1] ? RD_W'(-rdy) : RD_W'(rdy);

  assign fracx = rdx[RD_W-1] ? {1'b0, pos_x[FRAC_BITS-1:0]}
                             : 17'h10000 - {1'b0, pos_x[FRAC_BITS-1:0]};
  assign fracy = rdy[RD_W-1] ? {1'b0, pos_y[FRAC_BITS-1:0]}
                             : 17'h10000 - {1'b0, pos_y[FRAC_BITS-1:0]};
  assign sprod_x = 64'(fracx) * 64'(ddx);
  assign sprod_y = 64'(fracy) * 64'(ddy);

  assign sum_x = {1'b0, sdx} + {1'b0, ddx};
  assign sum_y = {1'b0, sdy} + {1'b0, ddy};
  assign cap_x = (sum_x > {1'b0, DIST_INF}) ? DIST_INF : sum_x[SD_W-1:0];
  assign cap_y = (sum_y > {1'b0, DIST_INF}) ? DIST_INF : sum_y[SD_W-1:0];

  assign sel_neg  = side ? rdy[RD_W-1] : rdx[RD_W-1];
  assign sel_zero = side ? (rdy == '0) : (rdx == '0);
  assign sel_abs  = side ? ay : ax;
  assign sel_pos  = side ? pos_y : pos_x;
  assign cur_cell = side ? my : mx;
  assign cell_adj = $signed({cur_cell[MC_W-1], cur_cell}) + $signed({{MC_W{1'b0}}, sel_neg});
  assign num      = $signed({cell_adj[MC_W], cell_adj, {FRAC_BITS{1'b0}}})
                  - $signed({{(NUM_W-POS_W){1'b0}}, sel_pos});
  assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dist_neg = num[NUM_W-1] ^ sel_neg;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (op)
      OP_DIV_CAM: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({it.column, {(FRAC_BITS + 1){1'b0}}});
        div_dvs   = DVS_W'(rs_eff);
      end
      OP_DIV_DX: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(1) << (2 * FRAC_BITS);
        div_dvs   = ax[DVS_W-1:0];
      end
      OP_DIV_DY: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(1) << (2 * FRAC_BITS);
        div_dvs   = ay[DVS_W-1:0];
      end
      OP_DIV_DIST: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({num_mag, {FRAC_BITS{1'b0}}});
        div_dvs   = sel_abs[DVS_W-1:0];
      end
      OP_DIV_LH: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({rs_eff, {FRAC_BITS{1'b0}}});
        div_dvs   = DVS_W'(wall_dist);
      end
      default: ;
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = {my[MAP_AW-1:0], mx[MAP_AW-1:0]};
    case (op)
      OP_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      OP_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = {it.map_row, it.map_col};
        ram_wdata = (it.cell_value == WALL_BYTE);
      end
      default: ;
    endcase
  end

  grc_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      found   <= 1'b0;
    end else begin
      if (op == OP_CLEAR) begin
        clr_cnt <= clr_cnt + MAP_ADDR_W'(1);
      end
      if (op == OP_LOAD) begin
        found <= 1'b0;
      end else if (op == OP_HIT) begin
        found <= 1'b1;
      end
    end
  end

  assign half_l = lh >> 1;
  assign half_r = rs_eff >> 1;
  assign ds_v   = (half_l > half_r) ? '0 : half_r - half_l;
  assign de_sum = half_l + half_r;
  assign rs_m1  = rs_eff - RS_W'(1);
  assign de_v   = (de_sum > rs_m1) ? rs_m1 : de_sum;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: it <= item;
      OP_TAKE_CAM: cam <= $signed({1'b0, div_q[CAM_W-2:0]}) - CAM_W'(1 << FRAC_BITS);
      OP_PROD: begin
        prod_x <= PROD_W'(plane_x * cam);
        prod_y <= PROD_W'(plane_y * cam);
      end
      OP_RAY: begin
        rdx <= RD_W'(dir_x) + RD_W'(prod_x >>> FRAC_BITS);
        rdy <= RD_W'(dir_y) + RD_W'(prod_y >>> FRAC_BITS);
      end
      OP_TAKE_DX: ddx <= (rdx == '0) ? DIST_INF : SD_W'(div_q);
      OP_TAKE_DY: ddy <= (rdy == '0) ? DIST_INF : SD_W'(div_q);
      OP_SIDE: begin
        sdx  <= (rdx == '0) ? DIST_INF : SD_W'(sprod_x >> FRAC_BITS);
        sdy  <= (rdy == '0) ? DIST_INF : SD_W'(sprod_y >> FRAC_BITS);
        mx   <= MC_W'(pos_x[POS_W-1:FRAC_BITS]);
        my   <= MC_W'(pos_y[POS_W-1:FRAC_BITS]);
        side <= 1'b0;
        n    <= '0;
      end
      OP_STEP: begin
        n <= n + STEP_W'(1);
        if (sdx < sdy) begin
          sdx  <= cap_x;
          mx   <= rdx[RD_W-1] ? mx - MC_W'(1) : mx + MC_W'(1);
          side <= 1'b0;
        end else begin
          sdy  <= cap_y;
          my   <= rdy[RD_W-1] ? my - MC_W'(1) : my + MC_W'(1);
          side <= 1'b1;
        end
      end
      OP_TAKE_DIST: begin
        if (sel_zero) begin
          wall_dist <= DIST_MAX;
        end else if (dist_neg) begin
          wall_dist <= '0;
        end else if (div_q > DVD_W'(DIST_MAX)) begin
          wall_dist <= DIST_MAX;
        end else begin
          wall_dist <= div_q[DIST_W-1:0];
        end
      end
      OP_TAKE_LH: begin
        if (wall_dist == '0 || div_q > DVD_W'(PIX_MAX)) begin
          lh <= PIX_MAX;
        end else begin
          lh <= div_q[PIX_W-1:0];
        end
      end
      OP_EMIT: begin
        res.column_out    <= it.column;
        res.wall_found    <= found;
        res.hit_side      <= found & side;
        res.hit_col       <= found ? mx[MAP_AW-1:0] : '0;
        res.hit_row       <= found ? my[MAP_AW-1:0] : '0;
        res.wall_distance <= found ? wall_dist : '0;
        res.line_height   <= found ? lh : '0;
        res.draw_start    <= found ? ds_v : '0;
        res.draw_end      <= found ? de_v : '0;
      end
      default: ;
    endcase
  end

  assign st.clear_last = (clr_cnt == '1);
  assign st.action     = it.action;
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.off_map    = mx[MC_W-1] | mx[MC_W-2] | my[MC_W-1] | my[MC_W-2];
  assign st.wall       = ram_rdata;
  assign st.steps_done = (n == STEP_W'(MAX_STEPS));
endmodule
`default_nettype wire

[rtl/core/grc_ctrl.sv]
`default_nettype none
`include "grid_ray_caster_dda_unit_macros.svh"
module grc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  grc_pkg::status_t  st,
  output grc_pkg::dp_op_t   op
);
  import grc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE,
    S_CAM_DIV, S_CAM_WAIT, S_PROD, S_RAY,
    S_DX_DIV, S_DX_WAIT, S_DY_DIV, S_DY_WAIT, S_SIDE,
    S_STEP, S_READ, S_CHECK,
    S_DIST_DIV, S_DIST_WAIT, S_LH_DIV, S_LH_WAIT, S_DONE
  } state_t;

  state_t state, state_next;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.action) begin
          state_next = S_CAM_DIV;
        end else begin
          op         = OP_WRITE;
          state_next = S_IDLE;
        end
      end
      S_CAM_DIV: begin
        op         = OP_DIV_CAM;
        state_next = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        if (st.div_done) begin
          op         = OP_TAKE_CAM;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        op         = OP_PROD;
        state_next = S_RAY;
      end
      S_RAY: begin
        op         = OP_RAY;
        state_next = S_DX_DIV;
      end
      S_DX_DIV: begin
        op         = OP_DIV_DX;
        state_next = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (st.div_done) begin
          op         = OP_TAKE_DX;
          state_next = S_DY_DIV;
        end
      end
      S_DY_DIV: begin
        op         = OP_DIV_DY;
        state_next = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (st.div_done) begin
          op         = OP_TAKE_DY;
          state_next = S_SIDE;
        end
      end
      S_SIDE: begin
        op         = OP_SIDE;
        state_next = S_STEP;
      end
      S_STEP: begin
        op         = OP_STEP;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = st.off_map ? S_DONE : S_CHECK;
      end
      S_CHECK: begin
        if (st.wall) begin
          op         = OP_HIT;
          state_next = S_DIST_DIV;
        end else if (st.steps_done) begin
          state_next = S_DONE;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DIST_DIV: begin
        op         = OP_DIV_DIST;
        state_next = S_DIST_WAIT;
      end
      S_DIST_WAIT: begin
        if (st.div_done) begin
          op         = OP_TAKE_DIST;
          state_next = S_LH_DIV;
        end
      end
      S_LH_DIV: begin
        op         = OP_DIV_LH;
        state_next = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        if (st.div_done) begin
          op         = OP_TAKE_LH;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (emit) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `GRC_ASSERT(a_wait_on_div, (state == S_CAM_WAIT || state == S_DX_WAIT || state == S_DY_WAIT || state == S_DIST_WAIT || state == S_LH_WAIT) |-> (st.div_busy || st.div_done))
  `GRC_ASSERT(a_emit_shows, (op == OP_EMIT) |=> out_valid)
  `GRC_ASSERT(a_step_bound, (state == S_STEP) |-> !st.steps_done)
endmodule
`default_nettype wire

[rtl/core/grid_ray_caster_dda_unit.sv]
// Map write: one write accepted at a time; the next item is taken once it is written.
// Ray cast: three divisions (each shifting out a 40-bit quotient), two more
// on a hit, then a step, a map read and a check per map cell walked; a column
// ends on a hit, off the map edge or after 130 steps; one item in flight.
// Reset (rst, synchronous) restores the registers and then clears the 4096-cell map
// in S_CLEAR, during which no item is accepted.
`default_nettype none
module grid_ray_caster_dda_unit (
  input  logic                          clk,
  input  logic                          rst,
  grc_item_if.sink                      req,
  grc_result_if.source                  rsp,
  input  logic                          cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grc_pkg::CFG_W-1:0]     cfg_data
);
  import grc_pkg::*;

  status_t st;
  dp_op_t  op;
  item_t   item;
  res_t    res;

  assign item.action     = req.action;
  assign item.column     = req.column;
  assign item.map_row    = req.map_row;
  assign item.map_col    = req.map_col;
  assign item.cell_value = req.cell_value;

  grc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .op        (op)
  );

  grc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .item      (item),
    .st        (st),
    .res       (res)
  );

  assign rsp.column_out    = res.column_out;
  assign rsp.wall_found    = res.wall_found;
  assign rsp.hit_side      = res.hit_side;
  assign rsp.hit_col       = res.hit_col;
  assign rsp.hit_row       = res.hit_row;
  assign rsp.wall_distance = res.wall_distance;
  assign rsp.line_height   = res.line_height;
  assign rsp.draw_start    = res.draw_start;
  assign rsp.draw_end      = res.draw_end;
endmodule
`default_nettype wire
